/* rtl/aligned_bump_allocator_core_defines.svh */
// Assertion macros shared by the allocator modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ALIGNED_BUMP_ALLOCATOR_CORE_DEFINES_SVH
`define ALIGNED_BUMP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define ABAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ABAL_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ABAL_ASSERT(lbl, prop, msg)
`define ABAL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/abal_pkg.sv */
package abal_pkg;

    localparam int CFG_W      = 21;
    localparam int SIZE_W     = 24;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int GRANT_W    = 32;
    localparam int CFG_IDX_W  = 1;

    localparam int POOL_ADDR_BITS_DEF = 20;

    localparam logic [CFG_W-1:0] POOL_BYTES_RST    = CFG_W'(1048576);
    localparam logic [CFG_W-1:0] DEFAULT_ALIGN_RST = CFG_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ALIGN = 1'd1;

    localparam logic [ACTION_W-1:0] ACT_ALLOC_ALIGNED = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC_DEFAULT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET         = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_REWIND        = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ALIGN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MARK_IGNORED = 3'd4;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_REJECT,
        OP_CLEAR,
        OP_REWIND
    } op_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SIZE_W-1:0]   alloc_size;
        logic [CFG_W-1:0]    alignment;
        logic [CFG_W-1:0]    rewind_mark;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CFG_W-1:0]    offset;
        logic [CFG_W-1:0]    used_bytes;
        logic [CFG_W-1:0]    available_bytes;
        logic [CFG_W-1:0]    peak_bytes;
        logic [GRANT_W-1:0]  grant_count;
    } rsp_t;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   size;
        logic [CFG_W-1:0]    align_mask;
        logic [CFG_W-1:0]    mark;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

/* rtl/abal_front.sv */
module abal_front
    import abal_pkg::*;
(
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req_word,
    input  logic [CFG_W-1:0] default_align,
    input  q_flags_t         q_flags,
    output logic             push,
    output cmd_t             cmd
);

    logic [CFG_W-1:0] align_sel;
    logic             align_ok;

    assign req_stall = q_flags.full;
    assign push      = req_valid && !q_flags.full;

    assign align_sel = (req_word.action == ACT_ALLOC_DEFAULT) ? default_align
                                                               : req_word.alignment;
    assign align_ok  = (align_sel != '0) && ((align_sel & (align_sel - 1'b1)) == '0);

    always_comb
    begin
        cmd.op         = OP_ALLOC;
        cmd.status     = ST_DONE;
        cmd.size       = req_word.alloc_size;
        cmd.align_mask = align_sel - 1'b1;
        cmd.mark       = req_word.rewind_mark;
        unique case (req_word.action) inside
            ACT_ALLOC_ALIGNED, ACT_ALLOC_DEFAULT:
            begin
                if (req_word.alloc_size == '0)
                begin
                    cmd.op     = OP_REJECT;
                    cmd.status = ST_ZERO_SIZE;
                end
                else if (!align_ok)
                begin
                    cmd.op     = OP_REJECT;
                    cmd.status = ST_BAD_ALIGN;
                end
            end
            ACT_RESET:
            begin
                cmd.op = OP_CLEAR;
            end
            default:
            begin
                cmd.op = OP_REWIND;
            end
        endcase
    end

endmodule

/* rtl/abal_queue.sv */
`include "aligned_bump_allocator_core_defines.svh"

module abal_queue
    import abal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cmd_t     push_cmd,
    input  logic     pop,
    output cmd_t     head_cmd,
    output q_flags_t q_flags
);

    cmd_t              q_mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign q_flags.full  = (count_reg == (QPTR_W+1)'(Q_DEPTH));
    assign q_flags.empty = (count_reg == '0);
    assign head_cmd      = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ABAL_ASSERT_NEVER(a_q_overflow, push && q_flags.full, "queue written while full")
    `ABAL_ASSERT_NEVER(a_q_underflow, pop && q_flags.empty, "queue read while empty")
    `ABAL_ASSERT(a_q_head_hold, (!q_flags.empty && !pop) |=> $stable(head_cmd), "queue head moved")

endmodule

/* rtl/abal_back.sv */
`include "aligned_bump_allocator_core_defines.svh"

module abal_back
    import abal_pkg::*;
#(
    parameter int POOL_ADDR_BITS = POOL_ADDR_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] pool_bytes,
    input  q_flags_t         q_flags,
    input  cmd_t             head_cmd,
    output logic             pop,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp_word
);

    localparam int CAP_BITS = (POOL_ADDR_BITS < CFG_W) ? POOL_ADDR_BITS : CFG_W;
    localparam logic [CFG_W:0] POOL_CAP = (CFG_W+1)'(1) << CAP_BITS;

    logic [CFG_W-1:0]    pool_total;
    logic [CFG_W:0]      start;
    logic [SIZE_W:0]     end_sum;
    logic                fits;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CFG_W-1:0]    offset_reg, offset_next;
    logic [CFG_W-1:0]    used_reg, used_next;
    logic [CFG_W-1:0]    peak_reg, peak_next;
    logic [GRANT_W-1:0]  grants_reg, grants_next;

    assign pool_total = ({1'b0, pool_bytes} < POOL_CAP) ? pool_bytes : POOL_CAP[CFG_W-1:0];

    assign pop = !q_flags.empty && (!rsp_valid_reg || !rsp_stall);

    assign start   = ({1'b0, used_reg} + {1'b0, head_cmd.align_mask})
                     & ~{1'b0, head_cmd.align_mask};
    assign end_sum = {{(SIZE_W-CFG_W){1'b0}}, start} + {1'b0, head_cmd.size};
    assign fits    = (end_sum <= {{(SIZE_W-CFG_W+1){1'b0}}, pool_total});

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        offset_next    = offset_reg;
        used_next      = used_reg;
        peak_next      = peak_reg;
        grants_next    = grants_reg;
        if (pop)
        begin
            rsp_valid_next = 1'b1;
            status_next    = head_cmd.status;
            offset_next    = '0;
            unique case (head_cmd.op)
                OP_ALLOC:
                begin
                    if (fits)
                    begin
                        offset_next = start[CFG_W-1:0];
                        used_next   = end_sum[CFG_W-1:0];
                        grants_next = grants_reg + 1'b1;
                        if (end_sum[CFG_W-1:0] > peak_reg)
                        begin
                            peak_next = end_sum[CFG_W-1:0];
                        end
                    end
                    else
                    begin
                        status_next = ST_NO_SPACE;
                    end
                end
                OP_REJECT:
                begin
                end
                OP_CLEAR:
                begin
                    used_next = '0;
                end
                OP_REWIND:
                begin
                    if (head_cmd.mark <= used_reg)
                    begin
                        used_next = head_cmd.mark;
                    end
                    else
                    begin
                        status_next = ST_MARK_IGNORED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
            peak_reg      <= '0;
            grants_reg    <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            grants_reg    <= grants_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        offset_reg <= offset_next;
    end

    assign rsp_valid                = rsp_valid_reg;
    assign rsp_word.status          = status_reg;
    assign rsp_word.offset          = offset_reg;
    assign rsp_word.used_bytes      = used_reg;
    assign rsp_word.available_bytes = (used_reg < pool_total) ? pool_total - used_reg : '0;
    assign rsp_word.peak_bytes      = peak_reg;
    assign rsp_word.grant_count     = grants_reg;

    `ABAL_ASSERT_NEVER(a_peak_below_used, peak_reg < used_reg, "peak fell below used offset")
    `ABAL_ASSERT(a_offset_only_on_grant, (rsp_valid_reg && status_reg != ST_DONE) |-> (offset_reg == '0), "offset set on a refused word")

endmodule

/* rtl/aligned_bump_allocator_core.sv */
// Bump allocator over a byte pool of configurable size, capped at 2**POOL_ADDR_BITS bytes.
// One request word is accepted per cycle unless the queue is full: the front classifies it
// (zero size, bad alignment, action) into a two-entry queue, and the back applies it to the
// used offset and loads the result register, one word per cycle unless rsp_stall holds a
// valid result. Each request passes the queue, then the result register. req_stall rises
// only when the queue is full, which happens when rsp_stall holds results back.
// Configuration must be written only while no request is in flight; the block does not check.
module aligned_bump_allocator_core
    import abal_pkg::*;
#(
    parameter int POOL_ADDR_BITS = POOL_ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp_word
);

    logic [CFG_W-1:0] pool_bytes_reg, pool_bytes_next;
    logic [CFG_W-1:0] default_align_reg, default_align_next;

    q_flags_t q_flags;
    logic     push;
    logic     pop;
    cmd_t     push_cmd;
    cmd_t     head_cmd;

    always_comb
    begin
        pool_bytes_next    = pool_bytes_reg;
        default_align_next = default_align_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_BYTES:    pool_bytes_next    = cfg_data;
                CFG_DEFAULT_ALIGN: default_align_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_bytes_reg    <= POOL_BYTES_RST;
            default_align_reg <= DEFAULT_ALIGN_RST;
        end
        else
        begin
            pool_bytes_reg    <= pool_bytes_next;
            default_align_reg <= default_align_next;
        end
    end

    abal_front u_front (
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_word      (req_word),
        .default_align (default_align_reg),
        .q_flags       (q_flags),
        .push          (push),
        .cmd           (push_cmd)
    );

    abal_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_flags  (q_flags)
    );

    abal_back #(
        .POOL_ADDR_BITS (POOL_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pool_bytes (pool_bytes_reg),
        .q_flags    (q_flags),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word)
    );

endmodule
